FILE: sv/jet_pkg.sv
// package for the julia escape-time engine
// types, register indexes and fixed-point helpers; no dependencies
package jet_pkg;

	localparam int COORD_BITS     = 12;
	localparam int ITER_LIMIT_DEF = 255;
	localparam int FRAC_BITS      = 28;
	localparam int CFG_IDX_BITS   = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_C_REAL    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_C_IMAG    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_LEFT_REAL = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_TOP_IMAG  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_STEP_X    = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_STEP_Y    = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_ITER  = 3'd6;

	typedef struct packed {
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  iteration_count;
		logic [11:0] out_x;
		logic [11:0] out_y;
	} out_item_t;

	// saturate a 38-bit signed sum to 32 bits
	function automatic logic signed [31:0] sat38(input logic signed [37:0] v);
		logic signed [31:0] r;
		if (v > 38'sh0_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -38'sh0_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

FILE: sv/jet_cell.sv
// one iteration cell of the escape-time chain, four register stages
// uses jet_pkg for the fraction width and the saturation helper
module jet_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vin,
	input  logic               din_done,
	input  logic [7:0]         din_cnt,
	input  logic [7:0]         din_limit,
	input  logic signed [31:0] din_zr,
	input  logic signed [31:0] din_zi,
	input  logic [11:0]        din_x,
	input  logic [11:0]        din_y,
	input  logic signed [31:0] c_real,
	input  logic signed [31:0] c_imag,
	output logic               vout,
	output logic               dout_done,
	output logic [7:0]         dout_cnt,
	output logic [7:0]         dout_limit,
	output logic signed [31:0] dout_zr,
	output logic signed [31:0] dout_zi,
	output logic [11:0]        dout_x,
	output logic [11:0]        dout_y
);

	localparam int FRAC_SHIFT = jet_pkg::FRAC_BITS;

	logic               v_s1, done_s1;
	logic [7:0]         cnt_s1, limit_s1;
	logic signed [31:0] zr_s1, zi_s1;
	logic signed [63:0] rr_s1, ii_s1, ri_s1;
	logic [11:0]        x_s1, y_s1;
	logic signed [64:0] diff;
	logic signed [37:0] nr, ni;
	logic signed [31:0] zr_n, zi_n;

	logic               v_s2, done_s2;
	logic [7:0]         cnt_s2, limit_s2;
	logic signed [31:0] zr_s2, zi_s2, ozr_s2, ozi_s2;
	logic [11:0]        x_s2, y_s2;

	logic               v_s3, done_s3;
	logic [7:0]         cnt_s3, limit_s3;
	logic signed [31:0] zr_s3, zi_s3, ozr_s3, ozi_s3;
	logic signed [63:0] mr_s3, mi_s3;
	logic [11:0]        x_s3, y_s3;
	logic [64:0]        mag;
	logic               stop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			vout <= 1'b0;
		end else begin
			v_s1 <= vin;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			vout <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		done_s1  <= din_done || (din_cnt >= din_limit);
		cnt_s1   <= din_cnt;
		limit_s1 <= din_limit;
		zr_s1    <= din_zr;
		zi_s1    <= din_zi;
		rr_s1    <= din_zr * din_zr;
		ii_s1    <= din_zi * din_zi;
		ri_s1    <= din_zr * din_zi;
		x_s1     <= din_x;
		y_s1     <= din_y;
	end

	assign diff = 65'(rr_s1) - 65'(ii_s1);
	assign nr   = 38'(diff >>> FRAC_SHIFT) + 38'(c_real);
	assign ni   = 38'(ri_s1 >>> (FRAC_SHIFT - 1)) + 38'(c_imag);
	assign zr_n = jet_pkg::sat38(nr);
	assign zi_n = jet_pkg::sat38(ni);

	// new point registered
	always_ff @(posedge clk) begin
		done_s2  <= done_s1;
		cnt_s2   <= cnt_s1;
		limit_s2 <= limit_s1;
		ozr_s2   <= zr_s1;
		ozi_s2   <= zi_s1;
		zr_s2    <= zr_n;
		zi_s2    <= zi_n;
		x_s2     <= x_s1;
		y_s2     <= y_s1;
	end

	// escape test on the new point, products registered
	always_ff @(posedge clk) begin
		done_s3  <= done_s2;
		cnt_s3   <= cnt_s2;
		limit_s3 <= limit_s2;
		ozr_s3   <= ozr_s2;
		ozi_s3   <= ozi_s2;
		zr_s3    <= zr_s2;
		zi_s3    <= zi_s2;
		mr_s3    <= zr_s2 * zr_s2;
		mi_s3    <= zi_s2 * zi_s2;
		x_s3     <= x_s2;
		y_s3     <= y_s2;
	end

	assign mag  = {1'b0, mr_s3} + {1'b0, mi_s3};
	assign stop = mag > 65'h0_0400_0000_0000_0000;

	always_ff @(posedge clk) begin
		dout_limit <= limit_s3;
		dout_x     <= x_s3;
		dout_y     <= y_s3;
		if (done_s3) begin
			dout_done <= 1'b1;
			dout_cnt  <= cnt_s3;
			dout_zr   <= ozr_s3;
			dout_zi   <= ozi_s3;
		end else begin
			dout_done <= stop;
			dout_cnt  <= stop ? cnt_s3 : cnt_s3 + 8'd1;
			dout_zr   <= zr_s3;
			dout_zi   <= zi_s3;
		end
	end

endmodule

FILE: sv/jet_map.sv
// maps a pixel item to its start point, two register stages
// uses jet_pkg for item types, the coordinate width and the default iteration limit
module jet_map #(
	parameter int ITER_LIMIT = jet_pkg::ITER_LIMIT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vin,
	input  jet_pkg::in_item_t  din,
	input  logic signed [31:0] left_real,
	input  logic signed [31:0] top_imag,
	input  logic [30:0]        step_x,
	input  logic [30:0]        step_y,
	input  logic [7:0]         max_iterations,
	output logic               vout,
	output logic [7:0]         limit,
	output logic signed [31:0] zr,
	output logic signed [31:0] zi,
	output logic [11:0]        x,
	output logic [11:0]        y
);

	logic                           v_s1;
	logic [jet_pkg::COORD_BITS-1:0] px, py;
	logic [42:0]                    ox_s1, oy_s1;
	logic [11:0]                    x_s1, y_s1;
	logic [7:0]                     lim_s1;

	assign px = din.pixel_x[jet_pkg::COORD_BITS-1:0];
	assign py = din.pixel_y[jet_pkg::COORD_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			vout <= 1'b0;
		end else begin
			v_s1 <= vin;
			vout <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		ox_s1  <= 43'(px) * 43'(step_x);
		oy_s1  <= 43'(py) * 43'(step_y);
		x_s1   <= 12'(px);
		y_s1   <= 12'(py);
		lim_s1 <= (max_iterations > 8'(ITER_LIMIT)) ? 8'(ITER_LIMIT) : max_iterations;
	end

	function automatic logic signed [31:0] sat44(input logic signed [44:0] v);
		logic signed [31:0] r;
		if (v > 45'sh7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -45'sh8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		zr    <= sat44(45'(left_real) + $signed({2'b00, ox_s1}));
		zi    <= sat44(45'(top_imag) + $signed({2'b00, oy_s1}));
		x     <= x_s1;
		y     <= y_s1;
		limit <= lim_s1;
	end

endmodule

FILE: sv/julia_escape_time.sv
// julia escape-time engine: pixel mapping, chain of iteration cells, result fifo
// uses jet_pkg, jet_map and jet_cell
// an item passes the map, every cell and the fifo write, on the same path for every pixel
// throughput: one item per cycle until 16 items are in flight or held, then one per result taken
// each cell does one iteration in four stages; a 16-slot credit count bounds the items in flight
// reset clears valid flags and fifo pointers, sets 16 credits and loads the register defaults
module julia_escape_time #(
	parameter int ITER_LIMIT = jet_pkg::ITER_LIMIT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  jet_pkg::in_item_t                   in_item,
	output logic                                out_valid,
	input  logic                                out_ready,
	output jet_pkg::out_item_t                  out_item,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [jet_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [31:0]                         cfg_data
);

	localparam int FD = 16;
	localparam int CW = $clog2(FD + 1);
	localparam int AW = $clog2(FD);

	logic signed [31:0] c_real_q, c_imag_q, left_real_q, top_imag_q;
	logic [30:0]        step_x_q, step_y_q;
	logic [7:0]         max_iter_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_real_q    <= -32'sd214748365;
			c_imag_q    <= 32'sd174483046;
			left_real_q <= -32'sd402653184;
			top_imag_q  <= -32'sd268435456;
			step_x_q    <= 31'd786432;
			step_y_q    <= 31'd699051;
			max_iter_q  <= 8'd255;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				jet_pkg::REG_C_REAL:    c_real_q    <= cfg_data;
				jet_pkg::REG_C_IMAG:    c_imag_q    <= cfg_data;
				jet_pkg::REG_LEFT_REAL: left_real_q <= cfg_data;
				jet_pkg::REG_TOP_IMAG:  top_imag_q  <= cfg_data;
				jet_pkg::REG_STEP_X:    step_x_q    <= cfg_data[30:0];
				jet_pkg::REG_STEP_Y:    step_y_q    <= cfg_data[30:0];
				jet_pkg::REG_MAX_ITER:  max_iter_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// credit count: items in flight plus held results never exceed the fifo depth
	logic [CW-1:0] credit_q;
	logic          in_fire, out_fire;

	assign in_ready = credit_q != '0;
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= CW'(FD);
		end else begin
			credit_q <= credit_q - CW'(in_fire) + CW'(out_fire);
		end
	end

	logic               v [ITER_LIMIT+1];
	logic               dn [ITER_LIMIT+1];
	logic [7:0]         ct [ITER_LIMIT+1];
	logic [7:0]         lm [ITER_LIMIT+1];
	logic signed [31:0] zr [ITER_LIMIT+1];
	logic signed [31:0] zi [ITER_LIMIT+1];
	logic [11:0]        xx [ITER_LIMIT+1];
	logic [11:0]        yy [ITER_LIMIT+1];

	jet_map #(.ITER_LIMIT(ITER_LIMIT)) u_map (
		.clk, .arst_n, .vin(in_fire), .din(in_item),
		.left_real(left_real_q), .top_imag(top_imag_q),
		.step_x(step_x_q), .step_y(step_y_q), .max_iterations(max_iter_q),
		.vout(v[0]), .limit(lm[0]), .zr(zr[0]), .zi(zi[0]), .x(xx[0]), .y(yy[0])
	);
	assign dn[0] = 1'b0;
	assign ct[0] = 8'd0;

	for (genvar g = 0; g < ITER_LIMIT; g++) begin : g_cell
		jet_cell u_cell (
			.clk, .arst_n, .vin(v[g]), .din_done(dn[g]), .din_cnt(ct[g]),
			.din_limit(lm[g]), .din_zr(zr[g]), .din_zi(zi[g]),
			.din_x(xx[g]), .din_y(yy[g]), .c_real(c_real_q), .c_imag(c_imag_q),
			.vout(v[g+1]), .dout_done(dn[g+1]), .dout_cnt(ct[g+1]),
			.dout_limit(lm[g+1]), .dout_zr(zr[g+1]), .dout_zi(zi[g+1]),
			.dout_x(xx[g+1]), .dout_y(yy[g+1])
		);
	end

	// result fifo, sized so the chain never needs to stall
	jet_pkg::out_item_t mem [FD];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          wr;

	assign wr        = v[ITER_LIMIT];
	assign out_valid = cnt_q != '0;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[wp_q] <= '{iteration_count: ct[ITER_LIMIT], out_x: xx[ITER_LIMIT],
				out_y: yy[ITER_LIMIT]};
		end
	end

	assign out_item = mem[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == AW'(FD - 1)) ? '0 : wp_q + AW'(1);
			end
			if (out_fire) begin
				rp_q <= (rp_q == AW'(FD - 1)) ? '0 : rp_q + AW'(1);
			end
			cnt_q <= cnt_q + CW'(wr) - CW'(out_fire);
		end
	end

	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(FD)) else $error("result fifo overflow");
	a_nofull: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> cnt_q < CW'(FD) || out_fire) else $error("write into full fifo");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.iteration_count <= 8'(ITER_LIMIT))
		else $error("count above limit");

endmodule
